// File: rtl/min_priority_queue_sorted_top_macros.svh
// assertion macros shared by the checker
`ifndef MIN_PRIORITY_QUEUE_SORTED_TOP_MACROS_SVH
`define MIN_PRIORITY_QUEUE_SORTED_TOP_MACROS_SVH

// same-cycle implication
`define MPQS_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("%m: check failed");

// next-cycle implication
`define MPQS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("%m: check failed");

`endif

// File: rtl/mpqs_pkg.sv
`default_nettype none
package mpqs_pkg;

	localparam int DATA_W        = 32;
	localparam int COUNT_W       = 5;
	localparam int DEFAULT_DEPTH = 16;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_UNDERFLOW = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_RD,
		ST_INS_WR,
		ST_RM_RD,
		ST_RM_WR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic  in_ready;
		logic  load;
		logic  rd_en;
		logic  wr_en;
		logic  addr_m1;
		logic  wr_src_val;
		logic  idx_inc;
		logic  idx_dec;
		logic  occ_inc;
		logic  occ_dec;
		logic  res_capture;
		logic  stat_set;
		stat_t stat;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic mode;
		logic empty;
		logic full;
		logic idx_zero;
		logic idx_last;
		logic less;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/mpqs_if.sv
`default_nettype none
interface mpqs_req_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic signed [mpqs_pkg::DATA_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface mpqs_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [mpqs_pkg::DATA_W-1:0]  min_value;
	logic [1:0]                         status;
	logic [mpqs_pkg::COUNT_W-1:0]        entry_count;

	modport source (output valid, output min_value, output status, output entry_count,
		input ready);
	modport sink (input valid, input min_value, input status, input entry_count,
		output ready);
endinterface
`default_nettype wire

// File: rtl/min_priority_queue_sorted_top.sv
// minimum-first priority queue of signed 32-bit values, held sorted in a
// single-port memory of QUEUE_DEPTH entries.
// req channel: one beat per operation, mode 0 inserts value, mode 1 removes
// the minimum. rsp channel: one beat per request with min_value (removed
// value, else 0), status (ok, underflow, full) and entry_count (low 5 bits of
// the occupancy after the operation).
// one operation at a time: req.ready is high only while the block is idle.
// after a beat is accepted, a dispatch state sends an insert into a full
// queue or a remove from an empty one straight to the finish state. an
// insert moves each larger entry up one slot, a read and a write each,
// then writes its value; a remove reads every stored entry, keeps the head
// as the result and moves each later entry down one slot. the shift loop
// moves entries one at a time, one memory read or write per cycle on the
// single memory port. req.ready rises again in the same cycle as rsp.valid.
// the response sits in an output register; if rsp.ready is low the block
// waits in its finish state until the register frees, then goes idle.
// reset (arst_n low) empties the queue and drops any pending response; the
// memory contents are not cleared and are only read below the occupancy.
`default_nettype none
module min_priority_queue_sorted_top #(
	parameter int QUEUE_DEPTH = mpqs_pkg::DEFAULT_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mpqs_req_if.sink     req,
	mpqs_rsp_if.source   rsp
);

	mpqs_pkg::cmd_t cmd;
	mpqs_pkg::sts_t sts;

	mpqs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	mpqs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule
`default_nettype wire

// File: rtl/mpqs_ctrl.sv
`default_nettype none
module mpqs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mpqs_pkg::sts_t  sts,
	output mpqs_pkg::cmd_t       cmd
);

	mpqs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpqs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mpqs_pkg::ST_IDLE: begin
				if (sts.in_valid) state_d = mpqs_pkg::ST_DISPATCH;
			end
			mpqs_pkg::ST_DISPATCH: begin
				if (sts.mode == mpqs_pkg::MODE_INSERT) begin
					state_d = sts.full ? mpqs_pkg::ST_FIN : mpqs_pkg::ST_INS_RD;
				end else begin
					state_d = sts.empty ? mpqs_pkg::ST_FIN : mpqs_pkg::ST_RM_RD;
				end
			end
			mpqs_pkg::ST_INS_RD: begin
				state_d = sts.idx_zero ? mpqs_pkg::ST_FIN : mpqs_pkg::ST_INS_WR;
			end
			mpqs_pkg::ST_INS_WR: begin
				state_d = sts.less ? mpqs_pkg::ST_FIN : mpqs_pkg::ST_INS_RD;
			end
			mpqs_pkg::ST_RM_RD: begin
				state_d = mpqs_pkg::ST_RM_WR;
			end
			mpqs_pkg::ST_RM_WR: begin
				state_d = sts.idx_last ? mpqs_pkg::ST_FIN : mpqs_pkg::ST_RM_RD;
			end
			mpqs_pkg::ST_FIN: begin
				if (!sts.out_busy) state_d = mpqs_pkg::ST_IDLE;
			end
			default: begin
				state_d = mpqs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.stat = mpqs_pkg::STAT_OK;
		case (state_q)
			mpqs_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = sts.in_valid;
			end
			mpqs_pkg::ST_DISPATCH: begin
				if (sts.mode == mpqs_pkg::MODE_INSERT) begin
					cmd.stat_set = sts.full;
					cmd.stat     = mpqs_pkg::STAT_FULL;
				end else begin
					cmd.stat_set = sts.empty;
					cmd.stat     = mpqs_pkg::STAT_UNDERFLOW;
				end
			end
			mpqs_pkg::ST_INS_RD: begin
				// slot zero reached: drop the value in at the head
				if (sts.idx_zero) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_src_val = 1'b1;
					cmd.occ_inc    = 1'b1;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.addr_m1 = 1'b1;
				end
			end
			mpqs_pkg::ST_INS_WR: begin
				cmd.wr_en = 1'b1;
				if (sts.less) begin
					cmd.wr_src_val = 1'b1;
					cmd.occ_inc    = 1'b1;
				end else begin
					cmd.idx_dec = 1'b1;
				end
			end
			mpqs_pkg::ST_RM_RD: begin
				cmd.rd_en = 1'b1;
			end
			mpqs_pkg::ST_RM_WR: begin
				cmd.idx_inc = 1'b1;
				cmd.occ_dec = sts.idx_last;
				if (sts.idx_zero) begin
					cmd.res_capture = 1'b1;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.addr_m1 = 1'b1;
				end
			end
			mpqs_pkg::ST_FIN: begin
				cmd.out_load = !sts.out_busy;
			end
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/mpqs_dp.sv
`default_nettype none
module mpqs_dp #(
	parameter int QUEUE_DEPTH = mpqs_pkg::DEFAULT_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	mpqs_req_if.sink             req,
	mpqs_rsp_if.source           rsp,
	input  wire mpqs_pkg::cmd_t  cmd,
	output mpqs_pkg::sts_t       sts
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int IW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = mpqs_pkg::DATA_W;
	localparam int CW = mpqs_pkg::COUNT_W;

	logic signed [DW-1:0] mem [QUEUE_DEPTH];
	logic signed [DW-1:0] rd_data_q;
	logic signed [DW-1:0] val_q;
	logic signed [DW-1:0] res_q;
	logic signed [DW-1:0] rsp_min_q;
	logic                 mode_q;
	mpqs_pkg::stat_t      stat_q;
	mpqs_pkg::stat_t      rsp_stat_q;
	logic [CW-1:0]        rsp_cnt_q;
	logic                 out_valid_q;
	logic [IW-1:0]        idx_q;
	logic [IW-1:0]        occ_q;
	logic [IW-1:0]        idx_m1;
	logic [AW-1:0]        addr;
	logic signed [DW-1:0] wr_data;
	logic [IW+CW-1:0]     occ_wide;

	assign idx_m1  = idx_q - IW'(1);
	assign addr    = cmd.addr_m1 ? idx_m1[AW-1:0] : idx_q[AW-1:0];
	assign wr_data = cmd.wr_src_val ? val_q : rd_data_q;
	assign occ_wide = (IW+CW)'(occ_q);

	// one port, read or write per cycle, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[addr] <= wr_data;
		if (cmd.rd_en) rd_data_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= (req.mode == mpqs_pkg::MODE_INSERT) ? occ_q : '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_m1;
			end
			if (cmd.occ_inc) begin
				occ_q <= occ_q + IW'(1);
			end else if (cmd.occ_dec) begin
				occ_q <= occ_q - IW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			val_q  <= req.value;
			res_q  <= '0;
			stat_q <= mpqs_pkg::STAT_OK;
		end else begin
			if (cmd.res_capture) res_q <= rd_data_q;
			if (cmd.stat_set) stat_q <= cmd.stat;
		end
		if (cmd.out_load) begin
			rsp_min_q  <= res_q;
			rsp_stat_q <= stat_q;
			rsp_cnt_q  <= occ_wide[CW-1:0];
		end
	end

	assign req.ready       = cmd.in_ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.min_value   = rsp_min_q;
	assign rsp.status      = rsp_stat_q;
	assign rsp.entry_count = rsp_cnt_q;

	assign sts.in_valid = req.valid;
	assign sts.mode     = mode_q;
	assign sts.empty    = (occ_q == '0);
	assign sts.full     = (occ_q == IW'(QUEUE_DEPTH));
	assign sts.idx_zero = (idx_q == '0);
	assign sts.idx_last = ((idx_q + IW'(1)) == occ_q);
	assign sts.less     = (rd_data_q < val_q);
	assign sts.out_busy = out_valid_q && !rsp.ready;

endmodule
`default_nettype wire

// File: rtl/mpqs_checker.sv
`default_nettype none
`include "min_priority_queue_sorted_top_macros.svh"
module mpqs_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire logic [mpqs_pkg::DATA_W-1:0]  rsp_min_value,
	input wire logic [1:0]                  rsp_status,
	input wire logic [mpqs_pkg::COUNT_W-1:0] rsp_entry_count
);

	logic                                         rsp_stall;
	logic                                         req_fire;
	logic                                         rsp_underflow;
	logic                                         rsp_empty_beat;
	logic                                         rsp_legal;
	logic [mpqs_pkg::DATA_W+mpqs_pkg::COUNT_W+1:0] rsp_bits;

	assign rsp_stall      = rsp_valid && !rsp_ready;
	assign req_fire       = req_valid && req_ready;
	assign rsp_bits       = {rsp_min_value, rsp_status, rsp_entry_count};
	assign rsp_underflow  = rsp_valid && (rsp_status == mpqs_pkg::STAT_UNDERFLOW);
	assign rsp_empty_beat = (rsp_min_value == '0) && (rsp_entry_count == '0);
	assign rsp_legal      = (rsp_status == mpqs_pkg::STAT_OK) ||
		((rsp_status == mpqs_pkg::STAT_UNDERFLOW || rsp_status == mpqs_pkg::STAT_FULL) &&
		rsp_min_value == '0);

	// a stalled response beat holds
	`MPQS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_bits))

	// one operation in flight: no second beat right after an accepted one
	`MPQS_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_fire, !req_ready)

	// underflow means the queue was and stays empty
	`MPQS_ASSERT_NOW(a_underflow, clk, arst_n, rsp_underflow, rsp_empty_beat)

	// a dropped insert or underflow never carries a value, code 3 never shows
	`MPQS_ASSERT_NOW(a_status_code, clk, arst_n, rsp_valid, rsp_legal)

endmodule

bind min_priority_queue_sorted_top mpqs_checker u_mpqs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_min_value   (rsp.min_value),
	.rsp_status      (rsp.status),
	.rsp_entry_count (rsp.entry_count)
);
`default_nettype wire
